@@ rtl/fixed_point_allpass_delay_defines.svh @@
// Assertion macros used by the allpass delay top level.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef FIXED_POINT_ALLPASS_DELAY_DEFINES_SVH
`define FIXED_POINT_ALLPASS_DELAY_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define APD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that stays active during reset.
`define APD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/apd_pkg.sv @@
// Types and constants for the fixed-point allpass delay block.
// Used by apd_mac and fixed_point_allpass_delay; depends on nothing.
package apd_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int SCALED_W  = 33;
  localparam int PROD_W    = 36;
  localparam int ACC_W     = 38;
  localparam int FRAC_BITS = 16;
  localparam int LEN_W     = 14;
  localparam int CFG_IDX_W = 2;

  // Saturation limits of the scaled input.
  localparam logic signed [SCALED_W-1:0] SCALED_MAX = {1'b0, {(SCALED_W-1){1'b1}}};
  localparam logic signed [SCALED_W-1:0] SCALED_MIN = {1'b1, {(SCALED_W-1){1'b0}}};

  // Saturation limits of the output sample.
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 2'd2;

  // Reset values of the registers.
  localparam logic signed [COEF_W-1:0] PRESCALE_RST = 18'sd65536;
  localparam logic signed [COEF_W-1:0] GAIN_RST     = 18'sd0;

  // Accumulator operations.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_SUB,
    ACC_ADD
  } acc_op_t;

  // Control word from the sequencer to the shared multiply-accumulate unit.
  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MULX,
    ST_SAT,
    ST_MULG1,
    ST_ACC1,
    ST_ACC2,
    ST_FIN
  } state_t;

endpackage

@@ rtl/apd_mac.sv @@
// Shared 18x18 signed multiplier with a registered product and accumulator.
// Depends on apd_pkg for widths and the control word.
module apd_mac (
  input  logic                                clk,
  input  apd_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [apd_pkg::COEF_W-1:0]   op_a,
  input  logic signed [apd_pkg::COEF_W-1:0]   op_b,
  input  logic signed [apd_pkg::SCALED_W-1:0] base,
  output logic signed [apd_pkg::PROD_W-1:0]   prod,
  output logic signed [apd_pkg::ACC_W-1:0]    acc
);

  logic signed [apd_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [apd_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [apd_pkg::ACC_W-1:0]  base_ext, prod_ext;

  // One multiplication per cycle, registered.
  always_comb begin
    prod_nxt = prod_r;
    if (ctrl.mul_en) begin
      prod_nxt = op_a * op_b;
    end
  end

  // Accumulator works on the product of the previous cycle.
  assign base_ext = {{(apd_pkg::ACC_W-apd_pkg::SCALED_W){base[apd_pkg::SCALED_W-1]}}, base};
  assign prod_ext = {{(apd_pkg::ACC_W-apd_pkg::PROD_W){prod_r[apd_pkg::PROD_W-1]}}, prod_r};

  always_comb begin
    case (ctrl.acc_op)
      apd_pkg::ACC_HOLD:     acc_nxt = acc_r;
      apd_pkg::ACC_LOAD_SUB: acc_nxt = base_ext - prod_ext;
      apd_pkg::ACC_ADD:      acc_nxt = acc_r + prod_ext;
      default:               acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

@@ rtl/fixed_point_allpass_delay.sv @@
// Top level of the fixed-point allpass delay: sequencer, delay memory, I/O.
// Depends on apd_pkg, apd_mac and fixed_point_allpass_delay_defines.svh.
//
//   channel  direction  handshake          payload
//   in       slave      in_tvalid/tready   tdata = sample_in
//   out      master     out_tvalid/tready  tdata = sample_out, tuser = clipped
//   cfg      write      cfg_we             cfg_index, cfg_wdata
//
// Each word passes through the steps MULX, SAT, MULG1, ACC1, ACC2 and FIN to the
// result register, and a new word is accepted only in the idle step after that. This is
// set by the single shared multiplier, which runs three products per word in sequence.
// After reset the delay memory is cleared one entry per cycle, all MAX_DELAY
// entries, while in_tready stays low; configuration writes are taken as ever.
// A result waiting on out_tready holds the block in its last step until taken.
module fixed_point_allpass_delay #(
  parameter int MAX_DELAY = 8192
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // [15:0] sample_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,  // [15:0] sample_out
  output logic                              out_tuser,  // [0] clipped
  input  logic                              cfg_we,
  input  logic [apd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apd_pkg::COEF_W-1:0]        cfg_wdata
);

`include "fixed_point_allpass_delay_defines.svh"

  localparam int AW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int LENW  = AW + 1;
  localparam int MEM_W = apd_pkg::SCALED_W + apd_pkg::SAMPLE_W;

  // Sequencer and control state.
  apd_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [LENW-1:0] len_r, len_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Configuration and payload registers.
  logic signed [apd_pkg::COEF_W-1:0]   prescale_r, prescale_nxt;
  logic signed [apd_pkg::COEF_W-1:0]   gain_r, gain_nxt;
  logic signed [apd_pkg::SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [apd_pkg::SCALED_W-1:0] scaled_r, scaled_nxt;
  logic signed [apd_pkg::SAMPLE_W-1:0] out_data_r, out_data_nxt;
  logic                                out_clip_r, out_clip_nxt;

  // Delay memory: scaled input in the upper bits, output sample in the lower.
  logic [MEM_W-1:0] mem [MAX_DELAY];
  logic [MEM_W-1:0] rd_r;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [MEM_W-1:0] mem_wd;
  logic             mem_re;

  // Shared unit signals.
  apd_pkg::mac_ctrl_t                  mac_ctrl;
  logic signed [apd_pkg::COEF_W-1:0]   op_a, op_b;
  logic signed [apd_pkg::PROD_W-1:0]   prod;
  logic signed [apd_pkg::ACC_W-1:0]    acc;
  logic signed [apd_pkg::SCALED_W-1:0] old_scaled;
  logic signed [apd_pkg::SAMPLE_W-1:0] old_out;

  // Datapath helpers.
  logic signed [apd_pkg::SCALED_W-1:0] scaled_sat;
  logic signed [apd_pkg::SAMPLE_W-1:0] y_sat;
  logic                                y_clip;
  logic                                in_fire, out_free;
  logic [LENW-1:0]                     pos_inc;
  logic [apd_pkg::LEN_W-1:0]           len_wr;

  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign old_scaled = rd_r[MEM_W-1:apd_pkg::SAMPLE_W];
  assign old_out    = rd_r[apd_pkg::SAMPLE_W-1:0];
  assign pos_inc    = {1'b0, pos_r} + LENW'(1);
  assign len_wr     = cfg_wdata[apd_pkg::LEN_W-1:0];

  // Saturate the scaled input to 33 bits.
  always_comb begin
    if (prod[apd_pkg::PROD_W-1:apd_pkg::SCALED_W-1] ==
        {(apd_pkg::PROD_W-apd_pkg::SCALED_W+1){prod[apd_pkg::SCALED_W-1]}}) begin
      scaled_sat = prod[apd_pkg::SCALED_W-1:0];
    end else if (prod[apd_pkg::PROD_W-1]) begin
      scaled_sat = apd_pkg::SCALED_MIN;
    end else begin
      scaled_sat = apd_pkg::SCALED_MAX;
    end
  end

  // Shift the accumulator down and saturate to 16 bits.
  always_comb begin
    y_clip = 1'b0;
    if (acc[apd_pkg::ACC_W-1:apd_pkg::FRAC_BITS+apd_pkg::SAMPLE_W-1] ==
        {(apd_pkg::ACC_W-apd_pkg::FRAC_BITS-apd_pkg::SAMPLE_W+1)
         {acc[apd_pkg::FRAC_BITS+apd_pkg::SAMPLE_W-1]}}) begin
      y_sat = acc[apd_pkg::FRAC_BITS+apd_pkg::SAMPLE_W-1:apd_pkg::FRAC_BITS];
    end else if (acc[apd_pkg::ACC_W-1]) begin
      y_sat  = apd_pkg::SAMPLE_MIN;
      y_clip = 1'b1;
    end else begin
      y_sat  = apd_pkg::SAMPLE_MAX;
      y_clip = 1'b1;
    end
  end

  // Multiplier operand selection per step.
  always_comb begin
    case (state_r)
      apd_pkg::ST_MULG1: begin
        op_a = gain_r;
        op_b = {scaled_r[apd_pkg::SCALED_W-1], scaled_r[apd_pkg::SCALED_W-1:apd_pkg::FRAC_BITS]};
      end
      apd_pkg::ST_ACC1: begin
        op_a = gain_r;
        op_b = {{(apd_pkg::COEF_W-apd_pkg::SAMPLE_W){old_out[apd_pkg::SAMPLE_W-1]}}, old_out};
      end
      default: begin
        op_a = {{(apd_pkg::COEF_W-apd_pkg::SAMPLE_W){x_r[apd_pkg::SAMPLE_W-1]}}, x_r};
        op_b = prescale_r;
      end
    endcase
  end

  apd_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .base (old_scaled),
    .prod (prod),
    .acc  (acc)
  );

  // Next state, sequencer outputs and register updates.
  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    pos_nxt         = pos_r;
    len_nxt         = len_r;
    prescale_nxt    = prescale_r;
    gain_nxt        = gain_r;
    x_nxt           = x_r;
    scaled_nxt      = scaled_r;
    out_data_nxt    = out_data_r;
    out_clip_nxt    = out_clip_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_op = apd_pkg::ACC_HOLD;
    mem_we          = 1'b0;
    mem_wa          = pos_r;
    mem_wd          = {scaled_r, y_sat};
    mem_re          = 1'b0;
    in_tready       = 1'b0;

    case (state_r)
      apd_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_DELAY - 1)) begin
          state_nxt = apd_pkg::ST_IDLE;
        end
      end
      apd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        mem_re    = 1'b1;
        if (in_tvalid) begin
          x_nxt     = in_tdata;
          state_nxt = apd_pkg::ST_MULX;
        end
      end
      apd_pkg::ST_MULX: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = apd_pkg::ST_SAT;
      end
      apd_pkg::ST_SAT: begin
        scaled_nxt = scaled_sat;
        state_nxt  = apd_pkg::ST_MULG1;
      end
      apd_pkg::ST_MULG1: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = apd_pkg::ST_ACC1;
      end
      apd_pkg::ST_ACC1: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = apd_pkg::ACC_LOAD_SUB;
        state_nxt       = apd_pkg::ST_ACC2;
      end
      apd_pkg::ST_ACC2: begin
        mac_ctrl.acc_op = apd_pkg::ACC_ADD;
        state_nxt       = apd_pkg::ST_FIN;
      end
      apd_pkg::ST_FIN: begin
        if (out_free) begin
          mem_we        = 1'b1;
          out_data_nxt  = y_sat;
          out_clip_nxt  = y_clip;
          out_valid_nxt = 1'b1;
          pos_nxt       = (pos_inc >= len_r) ? '0 : pos_inc[AW-1:0];
          state_nxt     = apd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = apd_pkg::ST_IDLE;
      end
    endcase

    // Configuration writes; a length write also restarts the position.
    if (cfg_we) begin
      case (cfg_index)
        apd_pkg::REG_PRESCALE: prescale_nxt = cfg_wdata;
        apd_pkg::REG_GAIN:     gain_nxt     = cfg_wdata;
        apd_pkg::REG_DELAY_LENGTH: begin
          pos_nxt = '0;
          if (len_wr == '0) begin
            len_nxt = LENW'(1);
          end else if (32'(len_wr) > 32'(MAX_DELAY)) begin
            len_nxt = LENW'(MAX_DELAY);
          end else begin
            len_nxt = LENW'(len_wr);
          end
        end
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apd_pkg::ST_CLEAR;
      clr_r       <= '0;
      pos_r       <= '0;
      len_r       <= LENW'(1);
      out_valid_r <= 1'b0;
      prescale_r  <= apd_pkg::PRESCALE_RST;
      gain_r      <= apd_pkg::GAIN_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      prescale_r  <= prescale_nxt;
      gain_r      <= gain_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    scaled_r   <= scaled_nxt;
    out_data_r <= out_data_nxt;
    out_clip_r <= out_clip_nxt;
  end

  // Delay memory with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= mem[pos_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

  // The position always stays inside the active delay length.
  `APD_ASSERT(a_pos_in_range, {1'b0, pos_r} < len_r, "position outside delay length")
  // No word is taken while the memory is being cleared.
  `APD_ASSERT_ALWAYS(a_no_accept_in_clear, (state_r == apd_pkg::ST_CLEAR) |-> !in_tready,
    "word accepted during memory clear")
  // An accepted word keeps the block busy on the next cycle.
  `APD_ASSERT(a_busy_after_accept, in_fire |=> !in_tready, "accepted while still busy")
  // A new result only appears after the final step.
  `APD_ASSERT(a_result_from_fin, $rose(out_tvalid) |-> $past(state_r == apd_pkg::ST_FIN),
    "result raised outside final step")

endmodule
